[sv/ffha_pkg.sv]
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared types and codes of the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

	localparam logic [1:0] OP_ALLOC  = 2'd0;
	localparam logic [1:0] OP_FREE   = 2'd1;
	localparam logic [1:0] OP_RESIZE = 2'd2;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam logic [1:0] ST_ADDR  = 2'd0;
	localparam logic [1:0] ST_NULL  = 2'd1;
	localparam logic [1:0] ST_LIMIT = 2'd2;
	localparam logic [1:0] ST_FULL  = 2'd3;

	localparam logic [1:0] CFG_HEADER = 2'd0;
	localparam logic [1:0] CFG_SPLIT  = 2'd1;
	localparam logic [1:0] CFG_LIMIT  = 2'd2;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [15:0] req_size;
		logic        addr_given;
		logic [15:0] payload_addr;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] result_addr;
		logic [15:0] copy_from;
		logic [15:0] copy_len;
	} rsp_t;

	typedef struct packed {
		logic [15:0] off;
		logic [15:0] size;
		logic        free;
	} entry_t;

	typedef enum logic [2:0] {
		C_HOLD = 3'd0,
		C_ROT  = 3'd1,
		C_INS  = 3'd2,
		C_DROP = 3'd3,
		C_WR   = 3'd4
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		entry_t   data;
	} cell_cmd_t;

endpackage

[sv/ffha_cell.sv]
// ----------------------------------------------------------------------------
// ffha_cell
// One table entry of the ring. Rotates, shifts for insert or drop, or is
// written, as the broadcast command says.
// ----------------------------------------------------------------------------
module ffha_cell #(
	parameter int IDX_W = 6,
	parameter int K     = 0
) (
	input  logic                clk,
	input  ffha_pkg::cell_cmd_t cmd,
	input  logic [IDX_W-1:0]    cmd_idx,
	input  ffha_pkg::entry_t    left,
	input  ffha_pkg::entry_t    right,
	output ffha_pkg::entry_t    q
);
	import ffha_pkg::*;

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(K);

	entry_t e_q;

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			C_ROT: begin
				e_q <= right;
			end
			C_INS: begin
				if (MY_IDX > cmd_idx) begin
					e_q <= left;
				end else if (MY_IDX == cmd_idx) begin
					e_q <= cmd.data;
				end
			end
			C_DROP: begin
				if (MY_IDX >= cmd_idx) begin
					e_q <= right;
				end
			end
			C_WR: begin
				if (MY_IDX == cmd_idx) begin
					e_q <= cmd.data;
				end
			end
			default: begin
			end
		endcase
	end

	assign q = e_q;

endmodule

[sv/ffha_ctrl.sv]
// ----------------------------------------------------------------------------
// ffha_ctrl
// Request sequencer: scans the rotating ring, decides, and issues the insert,
// drop and write commands to the cells.
// ----------------------------------------------------------------------------
module ffha_ctrl #(
	parameter int MAX_BLOCKS = 64,
	parameter int HEAP_BYTES = 65536
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  ffha_pkg::req_t         in_data,
	output logic                   out_valid,
	input  logic                   out_ready,
	output ffha_pkg::rsp_t         out_data,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [1:0]             cfg_index,
	input  logic [16:0]            cfg_data,
	input  ffha_pkg::entry_t       head,
	output ffha_pkg::cell_cmd_t    cmd,
	output logic [$clog2(MAX_BLOCKS)-1:0] cmd_idx
);
	import ffha_pkg::*;

	localparam int IW = $clog2(MAX_BLOCKS);
	localparam int CW = $clog2(MAX_BLOCKS + 1);
	localparam logic [CW-1:0] CNT_MAX = CW'(MAX_BLOCKS);
	localparam logic [IW-1:0] POS_LAST = IW'(MAX_BLOCKS - 1);
	localparam logic [16:0] LIM_CAP = (HEAP_BYTES < 65536) ? 17'(HEAP_BYTES) : 17'd65536;

	typedef enum logic [9:0] {
		S_IDLE   = 10'b0000000001,
		S_SCAN   = 10'b0000000010,
		S_EVAL   = 10'b0000000100,
		S_FIT_WR = 10'b0000001000,
		S_NEXT   = 10'b0000010000,
		S_RA     = 10'b0000100000,
		S_RB     = 10'b0001000000,
		S_RC     = 10'b0010000000,
		S_RD     = 10'b0100000000,
		S_DONE   = 10'b1000000000
	} state_t;

	typedef enum logic [1:0] {
		J_ALLOC = 2'd0,
		J_REL   = 2'd1,
		J_RSZ   = 2'd2
	} job_t;

	function automatic logic [15:0] sat_add(logic [15:0] a, logic [7:0] h, logic [15:0] b);
		logic [17:0] s;
		s = {2'b00, a} + {10'd0, h} + {2'b00, b};
		return (s > 18'h0FFFF) ? 16'hFFFF : s[15:0];
	endfunction

	state_t        state_q;
	job_t          job_q;
	logic          pass_fit_q, relmove_q;
	logic [15:0]   req_q, addr_q, old_size_q;
	logic          found_q, has_prev_q, has_next_q;
	logic [IW-1:0] idx_q, midx_q, pos_q;
	entry_t        cur_q, prev_q, prevcap_q, next_q, m_q;
	logic [CW-1:0] cnt_q;
	logic [16:0]   top_q, lim_q;
	logic [7:0]    hdr_q;
	logic [8:0]    smin_q;
	logic [1:0]    st_q;
	logic [15:0]   res_q, cfrom_q, clen_q;
	logic          out_valid_q;
	rsp_t          out_q;

	logic          head_ok, head_hit;
	logic [15:0]   spare;
	logic          split;
	entry_t        rem_e, ra_e, rc_e;
	logic [17:0]   grow;
	logic [16:0]   lim_eff;
	logic          over, room;
	logic          prev_merge;

	assign head_ok  = CW'(pos_q) < cnt_q;
	assign head_hit = head_ok && (pass_fit_q ? (head.free && head.size >= req_q)
	                                         : (head.off == addr_q));

	assign spare = cur_q.size - req_q;
	assign room  = cnt_q < CNT_MAX;
	assign split = (spare >= {7'd0, smin_q}) && (spare >= {8'd0, hdr_q}) && room;
	assign rem_e = '{off: cur_q.off + req_q + {8'd0, hdr_q}, size: spare - {8'd0, hdr_q},
	                 free: 1'b1};
	assign grow    = {1'b0, top_q} + {10'd0, hdr_q} + {2'b00, req_q};
	assign lim_eff = (lim_q < LIM_CAP) ? lim_q : LIM_CAP;
	assign over    = grow > {1'b0, lim_eff};

	assign prev_merge = has_prev_q && prevcap_q.free;
	assign ra_e = prev_merge ?
		'{off: prevcap_q.off, size: sat_add(prevcap_q.size, hdr_q, cur_q.size), free: 1'b1} :
		'{off: cur_q.off, size: cur_q.size, free: 1'b1};
	assign rc_e = '{off: m_q.off, size: sat_add(m_q.size, hdr_q, next_q.size), free: 1'b1};

	always_comb begin
		cmd.op   = C_HOLD;
		cmd.data = cur_q;
		cmd_idx  = idx_q;
		unique case (state_q)
			S_SCAN: begin
				cmd.op = C_ROT;
			end
			S_EVAL: begin
				if (pass_fit_q) begin
					if (found_q) begin
						if (split) begin
							cmd.op   = C_INS;
							cmd.data = rem_e;
							cmd_idx  = idx_q + IW'(1);
						end else begin
							cmd.op   = C_WR;
							cmd.data = '{off: cur_q.off, size: cur_q.size, free: 1'b0};
						end
					end else if (room && !over) begin
						cmd.op   = C_INS;
						cmd.data = '{off: top_q[15:0] + {8'd0, hdr_q}, size: req_q, free: 1'b0};
						cmd_idx  = IW'(cnt_q);
					end
				end
			end
			S_FIT_WR: begin
				cmd.op   = C_WR;
				cmd.data = '{off: cur_q.off, size: req_q, free: 1'b0};
			end
			S_RA: begin
				cmd.op   = C_WR;
				cmd.data = ra_e;
				cmd_idx  = prev_merge ? idx_q - IW'(1) : idx_q;
			end
			S_RB: begin
				cmd.op = C_DROP;
			end
			S_RC: begin
				cmd_idx = midx_q;
				if (!has_next_q) begin
					cmd.op = C_DROP;
				end else if (next_q.free) begin
					cmd.op   = C_WR;
					cmd.data = rc_e;
				end
			end
			S_RD: begin
				cmd.op  = C_DROP;
				cmd_idx = midx_q + IW'(1);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			top_q       <= '0;
			hdr_q       <= 8'd40;
			smin_q      <= 9'd80;
			lim_q       <= 17'd65536;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_HEADER: hdr_q  <= cfg_data[7:0];
					CFG_SPLIT:  smin_q <= cfg_data[8:0];
					CFG_LIMIT:  lim_q  <= cfg_data;
					default: begin
					end
				endcase
			end
			if (state_q == S_DONE && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						req_q     <= in_data.req_size;
						addr_q    <= in_data.payload_addr;
						st_q      <= ST_NULL;
						res_q     <= '0;
						cfrom_q   <= '0;
						clen_q    <= '0;
						found_q   <= 1'b0;
						pos_q     <= '0;
						relmove_q <= 1'b0;
						job_q     <= J_ALLOC;
						pass_fit_q <= 1'b1;
						if (in_data.opcode == OP_ALLOC ||
						    (in_data.opcode == OP_RESIZE && !in_data.addr_given)) begin
							state_q <= (in_data.req_size == 16'd0) ? S_DONE : S_SCAN;
						end else if (in_data.addr_given &&
						             (in_data.opcode == OP_FREE ||
						              (in_data.opcode == OP_RESIZE && in_data.req_size == 16'd0))) begin
							job_q      <= J_REL;
							pass_fit_q <= 1'b0;
							state_q    <= S_SCAN;
						end else if (in_data.opcode == OP_RESIZE) begin
							job_q      <= J_RSZ;
							pass_fit_q <= 1'b0;
							state_q    <= S_SCAN;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_SCAN: begin
					prev_q <= head;
					if (!found_q && head_hit) begin
						found_q    <= 1'b1;
						idx_q      <= pos_q;
						cur_q      <= head;
						prevcap_q  <= prev_q;
						has_prev_q <= pos_q != '0;
						has_next_q <= (CW'(pos_q) + CW'(1)) < cnt_q;
					end
					if (found_q && pos_q == idx_q + IW'(1)) begin
						next_q <= head;
					end
					pos_q <= pos_q + IW'(1);
					if (pos_q == POS_LAST) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					if (pass_fit_q) begin
						if (found_q) begin
							st_q  <= ST_ADDR;
							res_q <= cur_q.off;
							if (split) begin
								cnt_q   <= cnt_q + CW'(1);
								state_q <= S_FIT_WR;
							end else begin
								state_q <= S_NEXT;
							end
						end else begin
							state_q <= S_NEXT;
							if (!room) begin
								st_q <= ST_FULL;
							end else if (over) begin
								st_q <= ST_LIMIT;
							end else begin
								st_q  <= ST_ADDR;
								res_q <= top_q[15:0] + {8'd0, hdr_q};
								cnt_q <= cnt_q + CW'(1);
								top_q <= grow[16:0];
							end
						end
					end else if (!found_q) begin
						state_q <= S_DONE;
					end else if (job_q == J_RSZ && !relmove_q) begin
						if (cur_q.size >= req_q) begin
							st_q    <= ST_ADDR;
							res_q   <= addr_q;
							state_q <= S_DONE;
						end else begin
							old_size_q <= cur_q.size;
							pass_fit_q <= 1'b1;
							found_q    <= 1'b0;
							pos_q      <= '0;
							state_q    <= S_SCAN;
						end
					end else begin
						state_q <= S_RA;
					end
				end
				S_FIT_WR: begin
					state_q <= S_NEXT;
				end
				S_NEXT: begin
					if (job_q == J_RSZ && st_q == ST_ADDR) begin
						cfrom_q    <= addr_q;
						clen_q     <= old_size_q;
						relmove_q  <= 1'b1;
						pass_fit_q <= 1'b0;
						found_q    <= 1'b0;
						pos_q      <= '0;
						state_q    <= S_SCAN;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_RA: begin
					m_q     <= ra_e;
					midx_q  <= prev_merge ? idx_q - IW'(1) : idx_q;
					state_q <= prev_merge ? S_RB : S_RC;
				end
				S_RB: begin
					cnt_q   <= cnt_q - CW'(1);
					state_q <= S_RC;
				end
				S_RC: begin
					if (!has_next_q) begin
						cnt_q   <= cnt_q - CW'(1);
						state_q <= S_DONE;
					end else if (next_q.free) begin
						m_q     <= rc_e;
						state_q <= S_RD;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_RD: begin
					cnt_q   <= cnt_q - CW'(1);
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_q       <= '{status: st_q,
						                 result_addr: (st_q == ST_ADDR) ? res_q : 16'd0,
						                 copy_from: cfrom_q, copy_len: clen_q};
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

[sv/first_fit_heap_allocator_top.sv]
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_top
// First-fit heap allocator with split and coalesce over a ring of table cells.
// ----------------------------------------------------------------------------
// The block table lives in a ring of MAX_BLOCKS cells that rotates one place
// per cycle while the sequencer looks at the head cell, so every table scan
// walks all MAX_BLOCKS cells. An allocate or release takes one scan plus the
// table updates; a zero-size allocate, a release without an address and an
// unused opcode skip the scan and go straight to the answer. A resize that
// moves takes three scans. Requests are taken one at a time; a new request
// may be accepted while the previous result still waits in the output
// register. Configuration writes are taken in any cycle.
module first_fit_heap_allocator_top #(
	parameter int MAX_BLOCKS = 64,
	parameter int HEAP_BYTES = 65536
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  ffha_pkg::req_t in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output ffha_pkg::rsp_t out_data,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic [1:0]     cfg_index,
	input  logic [16:0]    cfg_data
);
	import ffha_pkg::*;

	localparam int IW = $clog2(MAX_BLOCKS);

	cell_cmd_t     cmd;
	logic [IW-1:0] cmd_idx;
	entry_t        ring [MAX_BLOCKS];

	ffha_ctrl #(
		.MAX_BLOCKS(MAX_BLOCKS),
		.HEAP_BYTES(HEAP_BYTES)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.head(ring[0]),
		.cmd(cmd),
		.cmd_idx(cmd_idx)
	);

	for (genvar k = 0; k < MAX_BLOCKS; k++) begin : g_cell
		ffha_cell #(
			.IDX_W(IW),
			.K(k)
		) u_cell (
			.clk(clk),
			.cmd(cmd),
			.cmd_idx(cmd_idx),
			.left(ring[(k + MAX_BLOCKS - 1) % MAX_BLOCKS]),
			.right(ring[(k + 1) % MAX_BLOCKS]),
			.q(ring[k])
		);
	end

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted while another is in progress");

	a_null_addr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != ST_ADDR |-> out_data.result_addr == 16'd0)
		else $error("address returned with a failing status");

	a_copy_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.copy_len != 16'd0 |-> out_data.status == ST_ADDR)
		else $error("copy hint given for a failed request");

endmodule

[tb/sv/tb_first_fit_heap_allocator_top.sv]
// ----------------------------------------------------------------------------
// tb_first_fit_heap_allocator_top
// Self-checking testbench of the first-fit heap allocator.
// ----------------------------------------------------------------------------
// Requests go in through the input channel and are predicted by a software copy
// of the block table. Results are compared in order, field by field, with the
// predicted ones. The run covers several register settings and several idling
// phases, and it includes one long stall of the output side.
// ----------------------------------------------------------------------------
module tb_first_fit_heap_allocator_top;
	timeunit 1ns;
	timeprecision 1ps;
	import ffha_pkg::*;

	localparam int NBLK = 64;
	localparam int HEAP = 65536;
	localparam int WATCHDOG_LIMIT = 20000;

	// Software copy of the allocator with its own table and registers.
	class heap_scoreboard;
		bit [15:0] tab_off[NBLK];
		bit [15:0] tab_size[NBLK];
		bit        tab_free[NBLK];
		int        used;
		int        top;
		int        hdr;
		int        spl;
		int        lim;
		rsp_t      pending[$];
		int        errors;

		function void clear();
			used = 0;
			top = 0;
			hdr = 40;
			spl = 80;
			lim = 65536;
			errors = 0;
			pending.delete();
		endfunction

		function void write_reg(logic [1:0] idx, logic [16:0] val);
			if (idx == CFG_HEADER)
				hdr = val[7:0];
			else if (idx == CFG_SPLIT)
				spl = val[8:0];
			else if (idx == CFG_LIMIT)
				lim = val;
		endfunction

		function void remove_at(int i);
			for (int k = i; k + 1 < used; k++) begin
				tab_off[k] = tab_off[k + 1];
				tab_size[k] = tab_size[k + 1];
				tab_free[k] = tab_free[k + 1];
			end
			used--;
		endfunction

		function void insert_at(int i, int off, int size, bit fr);
			for (int k = used; k > i; k--) begin
				tab_off[k] = tab_off[k - 1];
				tab_size[k] = tab_size[k - 1];
				tab_free[k] = tab_free[k - 1];
			end
			tab_off[i] = off[15:0];
			tab_size[i] = size[15:0];
			tab_free[i] = fr;
			used++;
		endfunction

		function int find_addr(int a);
			for (int i = 0; i < used; i++)
				if (tab_off[i] == a)
					return i;
			return used;
		endfunction

		function int grow_bound();
			int b;
			b = lim;
			if (b > HEAP)
				b = HEAP;
			if (b > 65536)
				b = 65536;
			return b;
		endfunction

		function logic [1:0] allocate(int req, output int a);
			int spare;
			int nt;
			a = 0;
			if (req == 0)
				return ST_NULL;
			for (int i = 0; i < used; i++) begin
				if (tab_free[i] && tab_size[i] >= req) begin
					spare = tab_size[i] - req;
					if (spare >= spl && spare >= hdr && used < NBLK) begin
						insert_at(i + 1, tab_off[i] + req + hdr, spare - hdr, 1'b1);
						tab_size[i] = 16'(req);
					end
					tab_free[i] = 1'b0;
					a = tab_off[i];
					return ST_ADDR;
				end
			end
			if (used >= NBLK)
				return ST_FULL;
			nt = top + hdr + req;
			if (nt > grow_bound())
				return ST_LIMIT;
			insert_at(used, top + hdr, req, 1'b0);
			a = (top + hdr) & 16'hFFFF;
			top = nt;
			return ST_ADDR;
		endfunction

		function int merged(int x, int y);
			int s;
			s = x + hdr + y;
			return (s > 65535) ? 65535 : s;
		endfunction

		function void release_addr(int a);
			int i;
			i = find_addr(a);
			if (i >= used)
				return;
			tab_free[i] = 1'b1;
			if (i > 0 && tab_free[i - 1]) begin
				tab_size[i - 1] = 16'(merged(tab_size[i - 1], tab_size[i]));
				remove_at(i);
				i--;
			end
			if (i + 1 < used) begin
				if (tab_free[i + 1]) begin
					tab_size[i] = 16'(merged(tab_size[i], tab_size[i + 1]));
					remove_at(i + 1);
				end
			end else begin
				remove_at(i);
			end
		endfunction

		function void note_request(req_t r);
			rsp_t o;
			int a;
			int i;
			int old;
			a = 0;
			o = '0;
			o.status = ST_NULL;
			if (r.opcode == OP_ALLOC) begin
				o.status = allocate(r.req_size, a);
			end else if (r.opcode == OP_FREE) begin
				if (r.addr_given)
					release_addr(r.payload_addr);
			end else if (r.opcode == OP_RESIZE) begin
				if (!r.addr_given) begin
					o.status = allocate(r.req_size, a);
				end else if (r.req_size == 0) begin
					release_addr(r.payload_addr);
				end else begin
					i = find_addr(r.payload_addr);
					if (i < used) begin
						if (tab_size[i] >= r.req_size) begin
							o.status = ST_ADDR;
							a = r.payload_addr;
						end else begin
							old = tab_size[i];
							o.status = allocate(r.req_size, a);
							if (o.status == ST_ADDR) begin
								o.copy_from = r.payload_addr;
								o.copy_len = 16'(old);
								release_addr(r.payload_addr);
							end
						end
					end
				end
			end
			if (o.status == ST_ADDR)
				o.result_addr = 16'(a);
			pending.push_back(o);
		endfunction

		function void check_result(rsp_t got);
			rsp_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h", $time, got);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.status !== e.status) begin
				$display("%0t: status expected %0d actual %0d", $time, e.status, got.status);
				errors++;
			end
			if (got.result_addr !== e.result_addr) begin
				$display("%0t: result_addr expected %h actual %h", $time,
					e.result_addr, got.result_addr);
				errors++;
			end
			if (got.copy_from !== e.copy_from) begin
				$display("%0t: copy_from expected %h actual %h", $time,
					e.copy_from, got.copy_from);
				errors++;
			end
			if (got.copy_len !== e.copy_len) begin
				$display("%0t: copy_len expected %h actual %h", $time,
					e.copy_len, got.copy_len);
				errors++;
			end
		endfunction

		// A table payload address, live blocks favoured; sometimes, or when none is picked, a random one.
		function logic [15:0] pick_addr();
			int live[$];
			for (int i = 0; i < used; i++)
				if (!tab_free[i] || $urandom_range(0, 3) == 0)
					live.push_back(tab_off[i]);
			if (live.size() == 0 || $urandom_range(0, 9) == 0)
				return 16'($urandom);
			return 16'(live[$urandom_range(0, live.size() - 1)]);
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	req_t in_data;
	logic out_valid;
	logic out_ready;
	rsp_t out_data;
	logic cfg_valid;
	logic cfg_ready;
	logic [1:0] cfg_index;
	logic [16:0] cfg_data;

	heap_scoreboard heap_model;
	int send_idle_pct;
	int recv_stall_pct;
	int hold_off_cycles;
	int quiet_cycles;
	bit timed_out;

	first_fit_heap_allocator_top u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Receiver side: random stalls plus an optional long hold-off.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready)
				heap_model.check_result(out_data);
			if (hold_off_cycles > 0) begin
				hold_off_cycles <= hold_off_cycles - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
			(cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT && !timed_out) begin
			timed_out = 1'b1;
			$display("Verification failed");
			$finish;
		end
	end

	// Valid stays up between back-to-back items; it drops only for idle gaps
	// and before the sender waits for the results to drain.
	task automatic send_request(req_t r);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(0, 99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		in_data <= r;
		do
			@(posedge clk);
		while (!in_ready);
		heap_model.note_request(r);
	endtask

	task automatic write_register(logic [1:0] idx, int val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= 17'(val);
		do
			@(posedge clk);
		while (!cfg_ready);
		heap_model.write_reg(idx, 17'(val));
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (heap_model.pending.size() != 0)
			@(posedge clk);
		repeat (4 * NBLK + 20)
			@(posedge clk);
	endtask

	function automatic req_t make_req(logic [1:0] op, int sz, bit given, int a);
		req_t r;
		r.opcode = op;
		r.req_size = 16'(sz);
		r.addr_given = given;
		r.payload_addr = 16'(a);
		return r;
	endfunction

	// Mostly small requests so the table fills and blocks get reused.
	task automatic random_request();
		int pick;
		int sz;
		req_t r;
		pick = $urandom_range(0, 99);
		case ($urandom_range(0, 9))
			0: sz = $urandom;
			1: sz = 0;
			2: sz = $urandom_range(0, 2000);
			default: sz = $urandom_range(1, 300);
		endcase
		if (pick < 45)
			r = make_req(OP_ALLOC, sz, 1'($urandom), $urandom);
		else if (pick < 75)
			r = make_req(OP_FREE, $urandom, $urandom_range(0, 9) != 0,
				heap_model.pick_addr());
		else if (pick < 97)
			r = make_req(OP_RESIZE, sz, $urandom_range(0, 7) != 0,
				heap_model.pick_addr());
		else
			r = make_req(OP_UNUSED, $urandom, 1'($urandom), $urandom);
		send_request(r);
	endtask

	initial begin
		heap_model = new();
		heap_model.clear();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_off_cycles = 0;
		quiet_cycles = 0;
		timed_out = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_HEADER;
		cfg_data = '0;
		repeat (10)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: zero size, splits, merges, resizes and odd opcodes.
		send_request(make_req(OP_ALLOC, 0, 0, 0));
		send_request(make_req(OP_ALLOC, 100, 0, 0));
		send_request(make_req(OP_ALLOC, 400, 0, 0));
		send_request(make_req(OP_ALLOC, 50, 0, 0));
		send_request(make_req(OP_FREE, 0, 1, 40 + 100 + 40));
		send_request(make_req(OP_ALLOC, 10, 0, 0));
		send_request(make_req(OP_FREE, 0, 1, 40));
		send_request(make_req(OP_FREE, 0, 1, 40));
		send_request(make_req(OP_FREE, 0, 0, 40));
		send_request(make_req(OP_FREE, 16'hFFFF, 1, 16'hFFFF));
		send_request(make_req(OP_RESIZE, 20, 0, 0));
		send_request(make_req(OP_RESIZE, 5, 1, 40));
		send_request(make_req(OP_RESIZE, 3000, 1, 40));
		send_request(make_req(OP_RESIZE, 0, 1, 40));
		send_request(make_req(OP_RESIZE, 10, 1, 12345));
		send_request(make_req(OP_ALLOC, 16'hFFFF, 0, 0));
		send_request(make_req(OP_UNUSED, 16'hFFFF, 1, 16'hFFFF));
		wait_drained();

		for (int phase = 0; phase < 8; phase++) begin
			case (phase)
				0: begin
					write_register(CFG_HEADER, 0);
					write_register(CFG_SPLIT, 0);
					write_register(CFG_LIMIT, 17'h10000);
				end
				1: begin
					write_register(CFG_HEADER, 255);
					write_register(CFG_SPLIT, 511);
					write_register(CFG_LIMIT, 3000);
				end
				2: begin
					write_register(CFG_HEADER, 8);
					write_register(CFG_SPLIT, 16);
					write_register(CFG_LIMIT, 0);
				end
				3: begin
					write_register(CFG_HEADER, 16);
					write_register(CFG_SPLIT, 0);
					write_register(CFG_LIMIT, 17'h1FFFF);
				end
				default: begin
					write_register(CFG_HEADER, $urandom_range(0, 255));
					write_register(CFG_SPLIT, $urandom_range(0, 511));
					write_register(CFG_LIMIT, $urandom_range(0, 17'h1FFFF));
				end
			endcase
			case (phase % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 71; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 71; end
				default: begin send_idle_pct = 28; recv_stall_pct = 28; end
			endcase
			if (phase == 2)
				hold_off_cycles = 2000;
			for (int n = 0; n < 200; n++)
				random_request();
			wait_drained();
		end

		if (heap_model.errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule

[filelist.f]
sv/ffha_pkg.sv
sv/ffha_cell.sv
sv/ffha_ctrl.sv
sv/first_fit_heap_allocator_top.sv
tb/sv/tb_first_fit_heap_allocator_top.sv
